[rtl/phlc_pkg.sv]
// ----------------------------------------------------------------------------
// phlc_pkg
// Shared types and codes for the horizontal-line polygon clipper.
// ----------------------------------------------------------------------------
package phlc_pkg;

    // kind of point loaded into the output register
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_CROSS  = 2'd1;
    localparam logic [1:0] KIND_MARK   = 2'd2;

    // bit positions in the output tuser
    localparam int TUSER_VALID = 0;
    localparam int TUSER_DONE  = 1;

    // controller -> datapath
    typedef struct packed {
        logic       accept;     // capture the input vertex
        logic       setup;      // load crossing operands
        logic       prep;       // form 3*b for the radix-4 multiply
        logic       mul;        // one radix-4 multiply step
        logic       div;        // one restoring divide step
        logic       out_ld;     // load the output register
        logic [1:0] out_kind;
        logic       out_end;
        logic       out_done;
        logic       edge_sel;   // 0: previous -> current, 1: current -> first
        logic       item_end;   // roll current vertex into previous
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic have_first;
        logic last;
        logic above_prev;
        logic above_cur;
        logic above_first;
        logic out_free;
    } t_stat;

endpackage

[rtl/phlc_ctrl.sv]
// ----------------------------------------------------------------------------
// phlc_ctrl
// Sequencer: walks the four result slots of an item (vertex and crossing of
// the incoming edge, vertex and crossing of the closing edge) and runs the
// multiply/divide iterations of the datapath for each crossing.
// ----------------------------------------------------------------------------
module phlc_ctrl #(
    parameter int COORD_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  phlc_pkg::t_stat i_stat,
    output phlc_pkg::t_cmd  o_cmd
);

    localparam int MH = (COORD_WIDTH + 1) / 2;   // radix-4 multiply steps
    localparam int CW = $clog2(COORD_WIDTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_VOUT  = 4'd2;
    localparam logic [3:0] ST_XSET  = 4'd3;
    localparam logic [3:0] ST_XPREP = 4'd4;
    localparam logic [3:0] ST_XMUL  = 4'd5;
    localparam logic [3:0] ST_XDIV  = 4'd6;
    localparam logic [3:0] ST_XOUT  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    localparam logic [1:0] SLOT_V0 = 2'd0;
    localparam logic [1:0] SLOT_X0 = 2'd1;
    localparam logic [1:0] SLOT_V1 = 2'd2;
    localparam logic [1:0] SLOT_X1 = 2'd3;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_slot, n_slot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    slot_en;
    logic          later;
    logic          slot_end;
    logic          none_out;

    // which results this item produces
    always_comb begin
        slot_en[SLOT_V0] = i_stat.have_first & i_stat.above_prev;
        slot_en[SLOT_X0] = i_stat.have_first & (i_stat.above_prev ^ i_stat.above_cur);
        slot_en[SLOT_V1] = i_stat.last & i_stat.above_cur;
        slot_en[SLOT_X1] = i_stat.last & (i_stat.above_cur ^ i_stat.above_first);
        none_out         = ~|slot_en;
    end

    always_comb begin
        case (r_slot)
            SLOT_V0: later = |slot_en[3:1];
            SLOT_X0: later = |slot_en[3:2];
            SLOT_V1: later = slot_en[3];
            default: later = 1'b0;
        endcase
        slot_end = ~later;
    end

    always_comb begin
        n_state         = r_state;
        n_slot          = r_slot;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.edge_sel  = r_slot[1];
        o_cmd.out_end   = slot_end;
        o_cmd.out_done  = i_stat.last & slot_end;
        o_cmd.out_kind  = phlc_pkg::KIND_VERTEX;
        o_in_ready      = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_slot       = SLOT_V0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (slot_en[r_slot]) begin
                    n_state = r_slot[0] ? ST_XSET : ST_VOUT;
                end else if (r_slot == SLOT_X1) begin
                    n_state = ST_FIN;
                end else begin
                    n_slot = r_slot + 2'd1;
                end
            end
            ST_VOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_slot       = r_slot + 2'd1;
                    n_state      = (r_slot == SLOT_X1) ? ST_FIN : ST_SCAN;
                end
            end
            ST_XSET: begin
                o_cmd.setup = 1'b1;
                n_cnt       = '0;
                n_state     = ST_XPREP;
            end
            ST_XPREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_XMUL;
            end
            ST_XMUL: begin
                o_cmd.mul = 1'b1;
                if (r_cnt == CW'(MH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_XDIV;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_XDIV: begin
                o_cmd.div = 1'b1;
                if (r_cnt == CW'(COORD_WIDTH - 1)) begin
                    n_state = ST_XOUT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_XOUT: begin
                o_cmd.out_kind = phlc_pkg::KIND_CROSS;
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_slot       = r_slot + 2'd1;
                    n_state      = (r_slot == SLOT_X1) ? ST_FIN : ST_SCAN;
                end
            end
            ST_FIN: begin
                // a last vertex with nothing kept still closes the polygon
                o_cmd.out_kind = phlc_pkg::KIND_MARK;
                o_cmd.out_end  = 1'b1;
                o_cmd.out_done = 1'b1;
                if (i_stat.last && none_out) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.item_end = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.item_end = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= SLOT_V0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_cnt   <= n_cnt;
        end
    end

    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_stat.out_free)
        else $error("output loaded while occupied");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.item_end |=> (r_state == ST_IDLE))
        else $error("item end did not return to idle");

endmodule

[rtl/phlc_dp.sv]
// ----------------------------------------------------------------------------
// phlc_dp
// Datapath: vertex registers, cut level, edge operand select, iterative
// radix-4 multiplier and restoring divider for the crossing x, and the
// output register.
// ----------------------------------------------------------------------------
module phlc_dp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata,
    input  logic [COORD_WIDTH-1:0] i_vx,
    input  logic [COORD_WIDTH-1:0] i_vy,
    input  logic                   i_last,
    input  phlc_pkg::t_cmd         i_cmd,
    output phlc_pkg::t_stat        o_stat,
    input  logic                   i_oready,
    output logic                   o_ovalid,
    output logic [COORD_WIDTH-1:0] o_px,
    output logic [COORD_WIDTH-1:0] o_py,
    output logic                   o_pvalid,
    output logic                   o_end,
    output logic                   o_done
);

    localparam int W  = COORD_WIDTH;
    localparam int MH = (W + 1) / 2;
    localparam int AW = 2 * MH;
    localparam int PW = 2 * W;

    logic [W-1:0]  r_cut;
    logic [W-1:0]  r_first_x, r_first_y, r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic          r_last, r_have_first;
    logic [AW-1:0] r_ma;
    logic [W-1:0]  r_mb, r_md, r_x0;
    logic [W+1:0]  r_mb3;
    logic [PW-1:0] r_acc;
    logic          r_neg;
    logic          r_ovalid, r_pvalid, r_end, r_done;
    logic [W-1:0]  r_px, r_py;

    logic [W-1:0]  p0x, p0y, p1x, p1y;
    logic [W:0]    num_w, dx_w, dy_w, num_n, dx_n, dy_n;
    logic [W-1:0]  mag_a, mag_b, mag_d;
    logic [PW-1:0] addend;
    logic [W:0]    dv_t, dv_diff;
    logic          dv_ge;
    logic [W:0]    qx;
    logic [W+1:0]  x_sum;
    logic [W-1:0]  x_sat;
    logic          out_free;

    assign p0x = i_cmd.edge_sel ? r_cur_x   : r_prev_x;
    assign p0y = i_cmd.edge_sel ? r_cur_y   : r_prev_y;
    assign p1x = i_cmd.edge_sel ? r_first_x : r_cur_x;
    assign p1y = i_cmd.edge_sel ? r_first_y : r_cur_y;

    // crossing operands as sign and magnitude
    always_comb begin
        num_w = {r_cut[W-1], r_cut} - {p0y[W-1], p0y};
        dx_w  = {p1x[W-1], p1x} - {p0x[W-1], p0x};
        dy_w  = {p1y[W-1], p1y} - {p0y[W-1], p0y};
        num_n = -num_w;
        dx_n  = -dx_w;
        dy_n  = -dy_w;
        mag_a = num_w[W] ? num_n[W-1:0] : num_w[W-1:0];
        mag_b = dx_w[W]  ? dx_n[W-1:0]  : dx_w[W-1:0];
        mag_d = dy_w[W]  ? dy_n[W-1:0]  : dy_w[W-1:0];
    end

    always_comb begin
        case (r_ma[AW-1 -: 2])
            2'd0:    addend = '0;
            2'd1:    addend = PW'(r_mb);
            2'd2:    addend = PW'({r_mb, 1'b0});
            default: addend = PW'(r_mb3);
        endcase
    end

    // restoring divide: high half is the remainder, low half fills with quotient
    always_comb begin
        dv_t    = {r_acc[PW-1:W], r_acc[W-1]};
        dv_diff = dv_t - {1'b0, r_md};
        dv_ge   = (dv_t >= {1'b0, r_md});
    end

    // x0 + signed quotient, negation folded into the carry-in, then saturate
    always_comb begin
        qx    = {1'b0, r_acc[W-1:0]} ^ {(W+1){r_neg}};
        x_sum = {{2{r_x0[W-1]}}, r_x0} + {qx[W], qx} + (W+2)'(r_neg);
        if (x_sum[W+1:W-1] == 3'b000 || x_sum[W+1:W-1] == 3'b111) begin
            x_sat = x_sum[W-1:0];
        end else if (x_sum[W+1]) begin
            x_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            x_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    assign out_free = ~r_ovalid | i_oready;

    always_comb begin
        o_stat.have_first  = r_have_first;
        o_stat.last        = r_last;
        o_stat.above_prev  = ($signed(r_prev_y)  >= $signed(r_cut));
        o_stat.above_cur   = ($signed(r_cur_y)   >= $signed(r_cut));
        o_stat.above_first = ($signed(r_first_y) >= $signed(r_cut));
        o_stat.out_free    = out_free;
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut        <= '0;
            r_have_first <= 1'b0;
            r_last       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_cut <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_last <= i_last;
            end
            if (i_cmd.item_end) begin
                r_have_first <= ~r_last;
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_oready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // vertex store and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_x <= i_vx;
            r_cur_y <= i_vy;
            if (!r_have_first) begin
                r_first_x <= i_vx;
                r_first_y <= i_vy;
            end
        end
        if (i_cmd.item_end) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.setup) begin
            r_ma  <= AW'(mag_a);
            r_mb  <= mag_b;
            r_md  <= mag_d;
            r_neg <= num_w[W] ^ dx_w[W] ^ dy_w[W];
            r_x0  <= p0x;
            r_acc <= '0;
        end
        if (i_cmd.prep) begin
            r_mb3 <= {2'b00, r_mb} + {1'b0, r_mb, 1'b0};
        end
        if (i_cmd.mul) begin
            r_acc <= {r_acc[PW-3:0], 2'b00} + addend;
            r_ma  <= {r_ma[AW-3:0], 2'b00};
        end
        if (i_cmd.div) begin
            r_acc <= {(dv_ge ? dv_diff[W-1:0] : dv_t[W-1:0]), r_acc[W-2:0], dv_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_end  <= i_cmd.out_end;
            r_done <= i_cmd.out_done;
            case (i_cmd.out_kind)
                phlc_pkg::KIND_VERTEX: begin
                    r_px     <= p0x;
                    r_py     <= p0y;
                    r_pvalid <= 1'b1;
                end
                phlc_pkg::KIND_CROSS: begin
                    r_px     <= x_sat;
                    r_py     <= r_cut;
                    r_pvalid <= 1'b1;
                end
                default: begin
                    r_px     <= '0;
                    r_py     <= '0;
                    r_pvalid <= 1'b0;
                end
            endcase
        end
    end

    assign o_ovalid = r_ovalid;
    assign o_px     = r_px;
    assign o_py     = r_py;
    assign o_pvalid = r_pvalid;
    assign o_end    = r_end;
    assign o_done   = r_done;

    a_cross_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_ld && i_cmd.out_kind == phlc_pkg::KIND_CROSS) |-> (r_md != '0))
        else $error("crossing with zero dy");

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_done) |-> r_end)
        else $error("polygon done without end of run");

    a_mark_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_pvalid) |-> r_done)
        else $error("empty marker outside polygon end");

endmodule

[rtl/polygon_horizontal_line_clip.sv]
// ----------------------------------------------------------------------------
// polygon_horizontal_line_clip
// Clips a streamed closed polygon to the half-plane y >= cut level.
//
//  channel  dir  data                                      marker
//  -------  ---  ----------------------------------------  ----------------
//  s_axis   in   tdata: vertex_x, vertex_y                 tlast: last_vertex
//  m_axis   out  tdata: point_x, point_y                    tlast: end_of_run
//                tuser: point_valid, polygon_done
//  cfg      in   i_cfg_wdata: cut_level on i_cfg_wen        -
//
// One item at a time. An item walks its result slots and loads an output for each
// kept vertex; each edge crossing also runs the iterative radix-4 multiplier and
// the one-bit-per-cycle divider.
// Synchronous active-low reset clears the cut level and polygon state.
// A stalled output holds the block in its current step; the next item is
// taken while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module polygon_horizontal_line_clip #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // vertex_x, vertex_y from bit 0 up, zero pad to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // point_x, point_y from bit 0 up, zero pad to bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // point_valid, polygon_done from bit 0 up
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((2 * W + 7) / 8) * 8;

    phlc_pkg::t_cmd  cmd;
    phlc_pkg::t_stat stat;
    logic [W-1:0]    px, py;
    logic            pvalid, done;

    phlc_ctrl #(
        .COORD_WIDTH (W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    phlc_dp #(
        .COORD_WIDTH (W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vx        (s_axis_tdata[W-1:0]),
        .i_vy        (s_axis_tdata[2*W-1:W]),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_oready    (m_axis_tready),
        .o_ovalid    (m_axis_tvalid),
        .o_px        (px),
        .o_py        (py),
        .o_pvalid    (pvalid),
        .o_end       (m_axis_tlast),
        .o_done      (done)
    );

    assign m_axis_tdata                       = DW'({py, px});
    assign m_axis_tuser[phlc_pkg::TUSER_VALID] = pvalid;
    assign m_axis_tuser[phlc_pkg::TUSER_DONE]  = done;

endmodule
